// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers for the RTL.
// Every check is sampled on the rising edge of i_clk and is held off while reset is active.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every sampled edge.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define ASSERT_IMPL(label, trig, cond, msg) \
    `ASSERT_CLK(label, (trig) |-> (cond), msg)

// A condition that must hold in the cycle after its trigger.
`define ASSERT_NEXT(label, trig, cond, msg) \
    `ASSERT_CLK(label, (trig) |=> (cond), msg)

`endif

// ----- hw/rtl/tsd_pkg.sv -----
// ----------------------------------------------------------------------------
// tsd_pkg
// Shared widths, codes and coordinate scaling for the touch swipe detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tsd_pkg;

    localparam int RAW_WIDTH = 12;
    localparam int RAW_MAX   = (1 << RAW_WIDTH) - 1;

    localparam int OP_W    = 1;
    localparam int TYPE_W  = 5;
    localparam int CODE_W  = 10;
    localparam int VAL_W   = 12;
    localparam int COORD_W = 12;
    localparam int KIND_W  = 2;
    localparam int DIR_W   = 3;
    localparam int MODE_W  = 2;
    localparam int THR_W   = 12;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    // Opcodes.
    localparam logic [OP_W-1:0] OP_EVENT = 1'b0;
    localparam logic [OP_W-1:0] OP_CLEAR = 1'b1;

    // Event types and codes.
    localparam logic [TYPE_W-1:0] EV_KEY = 5'd1;
    localparam logic [TYPE_W-1:0] EV_ABS = 5'd3;
    localparam logic [CODE_W-1:0] CODE_X     = 10'd0;
    localparam logic [CODE_W-1:0] CODE_Y     = 10'd1;
    localparam logic [CODE_W-1:0] CODE_TOUCH = 10'd330;

    // Gesture modes.
    localparam logic [MODE_W-1:0] MODE_SWIPE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DRAG  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TAP   = 2'd2;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_SWIPE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SMALL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DRAG  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TAP   = 2'd3;

    // Directions, two's complement.
    localparam logic signed [DIR_W-1:0] DIR_NONE  = 3'sd0;
    localparam logic signed [DIR_W-1:0] DIR_RIGHT = 3'sd1;
    localparam logic signed [DIR_W-1:0] DIR_LEFT  = -3'sd1;
    localparam logic signed [DIR_W-1:0] DIR_UP    = 3'sd2;
    localparam logic signed [DIR_W-1:0] DIR_DOWN  = -3'sd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MODE      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'b1;

    localparam logic [THR_W-1:0] THRESHOLD_RESET = 12'd20;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [TYPE_W-1:0] event_type;
        logic [CODE_W-1:0] event_code;
        logic [VAL_W-1:0]  event_value;
    } t_evt;

    // Clamp a raw value to the largest value the sensor can report.
    function automatic logic [VAL_W-1:0] sat_raw(input logic [VAL_W-1:0] v);
        logic [VAL_W-1:0] res;
        if (int'(v) > RAW_MAX) begin
            res = VAL_W'(RAW_MAX);
        end else begin
            res = v;
        end
        return res;
    endfunction

    // X * 800 / 1024 is X * 25 / 32.
    function automatic logic [COORD_W-1:0] scale_x(input logic [VAL_W-1:0] v);
        logic [VAL_W+4:0] p;
        p = (VAL_W+5)'(v) * (VAL_W+5)'(25);
        return p[VAL_W+4:5];
    endfunction

    // Y * 480 / 600 is (Y * 4) / 5; the divide by five is a reciprocal multiply.
    function automatic logic [COORD_W-1:0] scale_y(input logic [VAL_W-1:0] v);
        logic [VAL_W+1:0] n;
        logic [29:0]      p;
        n = {v, 2'b00};
        p = 30'(n) * 30'd52429;
        return p[29:18];
    endfunction

endpackage

// ----- hw/rtl/tsd_evt_if.sv -----
// ----------------------------------------------------------------------------
// tsd_evt_if
// Request channel that carries one touch event or a clear command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tsd_evt_if
    import tsd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [TYPE_W-1:0] event_type;
    logic [CODE_W-1:0] event_code;
    logic [VAL_W-1:0]  event_value;

    modport source (output valid, opcode, event_type, event_code, event_value, input ready);
    modport sink   (input valid, opcode, event_type, event_code, event_value, output ready);
endinterface

// ----- hw/rtl/tsd_res_if.sv -----
// ----------------------------------------------------------------------------
// tsd_res_if
// Request channel that carries one gesture result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tsd_res_if
    import tsd_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        result_kind;
    logic signed [DIR_W-1:0]  direction;
    logic [COORD_W-1:0]       first_x;
    logic [COORD_W-1:0]       first_y;
    logic [COORD_W-1:0]       last_x;
    logic [COORD_W-1:0]       last_y;

    modport source (output valid, result_kind, direction, first_x, first_y, last_x, last_y,
                    input ready);
    modport sink   (input valid, result_kind, direction, first_x, first_y, last_x, last_y,
                    output ready);
endinterface

// ----- hw/rtl/tsd_cfg_if.sv -----
// ----------------------------------------------------------------------------
// tsd_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tsd_cfg_if
    import tsd_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/touch_swipe_detector_unit.sv -----
// Flow: a request accepted into the input register is evaluated from there, and its result
// is written into the output register when that register is empty or is being emptied.
// Throughput: one request per cycle while the output register is not held by o_res.ready low.
// Reset (synchronous, active low) empties both registers, zeroes the coordinate state and loads
// gesture mode 0 and a swipe threshold of 20.
// ----------------------------------------------------------------------------
// touch_swipe_detector_unit
// Tracks touch coordinates from input events and reports swipe, drag and tap results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module touch_swipe_detector_unit
    import tsd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    tsd_evt_if.sink    i_evt,
    tsd_res_if.source  o_res,
    tsd_cfg_if.sink    i_cfg
);

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always taken; the index is a
    // single bit so both codes name a register.
    // ------------------------------------------------------------------
    logic [MODE_W-1:0] r_mode;
    logic [THR_W-1:0]  r_threshold;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_SWIPE;
            r_threshold <= THRESHOLD_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_MODE:      r_mode      <= i_cfg.data[MODE_W-1:0];
                REG_THRESHOLD: r_threshold <= i_cfg.data[THR_W-1:0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake. The input register holds one request; it moves into the
    // evaluation step whenever the output register is empty or is being
    // emptied in the same cycle. A request that produces no result still
    // waits for that slot, which keeps the control to a single condition.
    // ------------------------------------------------------------------
    logic r_s_vld;
    logic r_o_vld;
    t_evt r_evt;
    logic out_free;
    logic advance;

    assign out_free    = !r_o_vld || o_res.ready;
    assign advance     = r_s_vld && out_free;
    assign i_evt.ready = !r_s_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_vld <= 1'b0;
        end else if (i_evt.ready) begin
            r_s_vld <= i_evt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_evt.valid && i_evt.ready) begin
            r_evt.opcode      <= i_evt.opcode;
            r_evt.event_type  <= i_evt.event_type;
            r_evt.event_code  <= i_evt.event_code;
            r_evt.event_value <= i_evt.event_value;
        end
    end

    // ------------------------------------------------------------------
    // Coordinate state.
    // ------------------------------------------------------------------
    logic [COORD_W-1:0] r_begin_x, r_begin_y, r_latest_x, r_latest_y;

    // Evaluation of the request in the input register.
    logic [VAL_W-1:0]        raw;
    logic [COORD_W-1:0]      upd_bx, upd_by, upd_lx, upd_ly;
    logic [COORD_W-1:0]      ax, ay;
    logic                    is_abs_x, is_abs_y, is_release, all_set, start_set;
    logic                    emit;
    logic [KIND_W-1:0]       kind;
    logic signed [DIR_W-1:0] dir;

    always_comb begin
        raw      = sat_raw(r_evt.event_value);
        is_abs_x = (r_evt.event_type == EV_ABS) && (r_evt.event_code == CODE_X);
        is_abs_y = (r_evt.event_type == EV_ABS) && (r_evt.event_code == CODE_Y);

        // A start coordinate latches only while it is still zero.
        upd_bx = r_begin_x;
        upd_lx = r_latest_x;
        upd_by = r_begin_y;
        upd_ly = r_latest_y;
        if (is_abs_x) begin
            upd_lx = scale_x(raw);
            if (r_begin_x == '0) begin
                upd_bx = upd_lx;
            end
        end
        if (is_abs_y) begin
            upd_ly = scale_y(raw);
            if (r_begin_y == '0) begin
                upd_by = upd_ly;
            end
        end

        start_set  = (upd_bx != '0) && (upd_by != '0);
        all_set    = start_set && (upd_lx != '0) && (upd_ly != '0);
        is_release = (r_evt.event_type == EV_KEY) && (r_evt.event_code == CODE_TOUCH)
                     && (raw == '0);

        ax = (upd_lx > upd_bx) ? upd_lx - upd_bx : upd_bx - upd_lx;
        ay = (upd_ly > upd_by) ? upd_ly - upd_by : upd_by - upd_ly;

        // The dominant axis decides the direction when its travel clears the
        // threshold; a release that fails both tests is reported as too small.
        emit = 1'b0;
        kind = KIND_SMALL;
        dir  = DIR_NONE;
        priority if (r_mode == MODE_SWIPE && is_release && all_set) begin
            emit = 1'b1;
            priority if (ax > ay && ax > r_threshold) begin
                kind = KIND_SWIPE;
                dir  = (upd_lx > upd_bx) ? DIR_RIGHT : DIR_LEFT;
            end else if (ay > ax && ay > r_threshold) begin
                kind = KIND_SWIPE;
                dir  = (upd_ly < upd_by) ? DIR_UP : DIR_DOWN;
            end else begin
                kind = KIND_SMALL;
            end
        end else if (r_mode == MODE_DRAG && all_set) begin
            emit = 1'b1;
            kind = KIND_DRAG;
        end else if (r_mode == MODE_TAP && start_set) begin
            emit = 1'b1;
            kind = KIND_TAP;
        end else begin
            emit = 1'b0;
        end

        // A clear command touches nothing but the coordinates.
        if (r_evt.opcode == OP_CLEAR) begin
            emit = 1'b0;
        end
    end

    // The state clears after every result and on a clear command.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_begin_x  <= '0;
            r_begin_y  <= '0;
            r_latest_x <= '0;
            r_latest_y <= '0;
        end else if (advance) begin
            if (r_evt.opcode == OP_CLEAR || emit) begin
                r_begin_x  <= '0;
                r_begin_y  <= '0;
                r_latest_x <= '0;
                r_latest_y <= '0;
            end else begin
                r_begin_x  <= upd_bx;
                r_begin_y  <= upd_by;
                r_latest_x <= upd_lx;
                r_latest_y <= upd_ly;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register. The coordinates carry the state just before the
    // clear that follows a result.
    // ------------------------------------------------------------------
    logic [KIND_W-1:0]       r_kind;
    logic signed [DIR_W-1:0] r_dir;
    logic [COORD_W-1:0]      r_fx, r_fy, r_lx, r_ly;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (out_free) begin
            r_o_vld <= advance && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_kind <= kind;
            r_dir  <= dir;
            r_fx   <= upd_bx;
            r_fy   <= upd_by;
            r_lx   <= upd_lx;
            r_ly   <= upd_ly;
        end
    end

    assign o_res.valid       = r_o_vld;
    assign o_res.result_kind = r_kind;
    assign o_res.direction   = r_dir;
    assign o_res.first_x     = r_fx;
    assign o_res.first_y     = r_fy;
    assign o_res.last_x      = r_lx;
    assign o_res.last_y      = r_ly;

    // ------------------------------------------------------------------
    // Checks.
    // ------------------------------------------------------------------
    `ASSERT_NEXT(a_clear_after_result, advance && emit,
        r_begin_x == '0 && r_begin_y == '0 && r_latest_x == '0 && r_latest_y == '0,
        "coordinates not cleared after a result")
    `ASSERT_IMPL(a_no_advance_when_held, r_o_vld && !o_res.ready, !advance,
        "request evaluated while the output register is held")
    `ASSERT_IMPL(a_swipe_has_direction, r_o_vld && r_kind == KIND_SWIPE, r_dir != DIR_NONE,
        "swipe result without a direction")
    `ASSERT_IMPL(a_stall_means_full, !i_evt.ready, r_s_vld && r_o_vld,
        "input stalled while a register is free")

endmodule
